// ----- sv/imhtq_pkg.sv -----
`timescale 1ns / 1ps

package imhtq_pkg;

    // Fixed geometry of the queue
    localparam int CAPACITY     = 64;
    localparam int THREAD_COUNT = 64;
    localparam int KEY_BITS     = 31;
    localparam int TID_W        = 6;
    localparam int SLOT_AW      = 6;
    localparam int CNT_W        = 7;
    localparam int IN_W         = 40;
    localparam int OUT_W        = 48;

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [TID_W-1:0]    tid_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    // One heap slot
    typedef struct packed {
        key_t key;
        tid_t thr;
    } entry_t;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_PEEK   = 2'd3
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FULL    = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_PRESENT = 3'd4
    } status_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE        = 4'd0,
        OP_LOAD_ERR    = 4'd1,
        OP_LOAD_INS    = 4'd2,
        OP_LOAD_TOP    = 4'd3,
        OP_LOAD_REM    = 4'd4,
        OP_READ_HOLE   = 4'd5,
        OP_TAKE_HOLE   = 4'd6,
        OP_READ_PARENT = 4'd7,
        OP_MOVE_UP     = 4'd8,
        OP_READ_KIDS   = 4'd9,
        OP_MOVE_DOWN   = 4'd10,
        OP_PLACE       = 4'd11
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t err;
        logic    emit;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_code_t in_cmd;
        logic      present;
        logic      full;
        logic      empty;
        logic      is_peek;
        logic      hole_last;
        logic      last_less;
        logic      at_root;
        logic      up_move;
        logic      has_left;
        logic      dn_move;
    } dp_flags_t;

endpackage

// ----- sv/indexed_min_heap_timer_queue.sv -----
`timescale 1ns / 1ps

// Timer queue of sleeping threads: a binary min-heap on wakeup time with a
// position map per thread id, so a thread can be removed from any slot.
// Commands are insert, pop earliest, remove by id and peek earliest; each
// gives one result with a status, the thread and key for pop or peek, and
// the occupancy afterward. One command is in work at a time. An error
// result is loaded and emitted directly; a peek reads the root first.
// Insert climbs from a new last slot one level at a time until it reaches
// the root or a compare stops it. Pop reads the root and the last slot;
// pop and remove take the last entry into the hole and sift it up or down,
// unless the hole was the last slot. Remove first looks up the slot of the
// thread in the position map. The next command is accepted in the cycle
// after the result is loaded. Each level takes a registered read of the
// slot memory followed by a write through its single write port. A result
// waits in an output register while the next command is accepted; a command
// that finishes while that register is still full holds until it is taken.
module indexed_min_heap_timer_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // cmd[1:0], thread_id[7:2], wakeup_time[38:8]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // status[2:0], out_thread[8:3],
                                       // out_wakeup[39:9], occupancy[46:40]
);

    imhtq_pkg::ctrl_cmd_t cmd;
    imhtq_pkg::dp_flags_t flags;

    imhtq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .flags     (flags),
        .cmd       (cmd)
    );

    imhtq_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata),
        .cmd      (cmd),
        .flags    (flags)
    );

endmodule

// ----- sv/imhtq_ctrl.sv -----
`timescale 1ns / 1ps

module imhtq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  imhtq_pkg::dp_flags_t flags,
    output imhtq_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_POS    = 8'b0000_0010,
        S_HOLE   = 8'b0000_0100,
        S_UP     = 8'b0000_1000,
        S_UP_CMP = 8'b0001_0000,
        S_DN     = 8'b0010_0000,
        S_DN_CMP = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Sequence one command through the datapath
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = imhtq_pkg::OP_NONE;
        cmd.err    = imhtq_pkg::ST_OK;
        cmd.emit   = 1'b0;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (flags.in_cmd)
                        imhtq_pkg::CMD_INSERT:
                        begin
                            priority if (flags.present)
                            begin
                                cmd.op     = imhtq_pkg::OP_LOAD_ERR;
                                cmd.err    = imhtq_pkg::ST_PRESENT;
                                state_next = S_DONE;
                            end
                            else if (flags.full)
                            begin
                                cmd.op     = imhtq_pkg::OP_LOAD_ERR;
                                cmd.err    = imhtq_pkg::ST_FULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                cmd.op     = imhtq_pkg::OP_LOAD_INS;
                                state_next = S_UP;
                            end
                        end
                        imhtq_pkg::CMD_REMOVE:
                        begin
                            if (!flags.present)
                            begin
                                cmd.op     = imhtq_pkg::OP_LOAD_ERR;
                                cmd.err    = imhtq_pkg::ST_ABSENT;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                cmd.op     = imhtq_pkg::OP_LOAD_REM;
                                state_next = S_POS;
                            end
                        end
                        default:
                        begin
                            if (flags.empty)
                            begin
                                cmd.op     = imhtq_pkg::OP_LOAD_ERR;
                                cmd.err    = imhtq_pkg::ST_EMPTY;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                cmd.op     = imhtq_pkg::OP_LOAD_TOP;
                                state_next = S_HOLE;
                            end
                        end
                    endcase
                end
            end
            S_POS:
            begin
                cmd.op     = imhtq_pkg::OP_READ_HOLE;
                state_next = S_HOLE;
            end
            S_HOLE:
            begin
                cmd.op = imhtq_pkg::OP_TAKE_HOLE;
                priority if (flags.is_peek || flags.hole_last)
                    state_next = S_DONE;
                else if (flags.last_less)
                    state_next = S_UP;
                else
                    state_next = S_DN;
            end
            S_UP:
            begin
                if (flags.at_root)
                begin
                    cmd.op     = imhtq_pkg::OP_PLACE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = imhtq_pkg::OP_READ_PARENT;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (flags.up_move)
                begin
                    cmd.op     = imhtq_pkg::OP_MOVE_UP;
                    state_next = S_UP;
                end
                else
                begin
                    cmd.op     = imhtq_pkg::OP_PLACE;
                    state_next = S_DONE;
                end
            end
            S_DN:
            begin
                if (!flags.has_left)
                begin
                    cmd.op     = imhtq_pkg::OP_PLACE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = imhtq_pkg::OP_READ_KIDS;
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                if (flags.dn_move)
                begin
                    cmd.op     = imhtq_pkg::OP_MOVE_DOWN;
                    state_next = S_DN;
                end
                else
                begin
                    cmd.op     = imhtq_pkg::OP_PLACE;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result until it is taken
    always_comb
    begin
        priority if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- sv/imhtq_dp.sv -----
`timescale 1ns / 1ps

module imhtq_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [imhtq_pkg::IN_W-1:0]   in_data,
    output logic [imhtq_pkg::OUT_W-1:0]  out_data,
    input  imhtq_pkg::ctrl_cmd_t         cmd,
    output imhtq_pkg::dp_flags_t         flags
);

    // Heap slots and the thread position map
    imhtq_pkg::entry_t slot_mem [imhtq_pkg::CAPACITY];
    imhtq_pkg::cnt_t   pos_mem  [imhtq_pkg::THREAD_COUNT];

    logic [imhtq_pkg::THREAD_COUNT-1:0] valid_reg, valid_next;
    imhtq_pkg::cnt_t                    count_reg, count_next;

    imhtq_pkg::cmd_code_t cmd_reg;
    imhtq_pkg::tid_t      tid_reg;
    imhtq_pkg::entry_t    cur_reg;
    imhtq_pkg::cnt_t      idx_reg;
    imhtq_pkg::entry_t    rd_a_reg, rd_b_reg;
    imhtq_pkg::cnt_t      pos_rd_reg;
    imhtq_pkg::status_t   res_status_reg;
    imhtq_pkg::tid_t      res_thr_reg;
    imhtq_pkg::key_t      res_key_reg;
    logic [imhtq_pkg::OUT_W-1:0] out_data_reg;

    imhtq_pkg::cmd_code_t in_cmd;
    imhtq_pkg::tid_t      in_tid;
    imhtq_pkg::key_t      in_key;

    logic [imhtq_pkg::CNT_W:0]     left_idx, right_idx;
    imhtq_pkg::cnt_t               cnt_m1, idx_m1, parent_m1, pos_m1, left_m1;
    logic                          has_right, dn_left, dn_right;
    logic                          rd_en, slot_we, pos_we;
    logic [imhtq_pkg::SLOT_AW-1:0] addr_a, addr_b, slot_waddr;
    imhtq_pkg::entry_t             slot_wdata, child;
    imhtq_pkg::tid_t               pos_waddr;

    assign in_cmd = imhtq_pkg::cmd_code_t'(in_data[1:0]);
    assign in_tid = in_data[7:2];
    assign in_key = in_data[38:8];

    // Slot arithmetic around the current index
    assign cnt_m1    = count_reg - imhtq_pkg::CNT_W'(1);
    assign idx_m1    = idx_reg - imhtq_pkg::CNT_W'(1);
    assign parent_m1 = (idx_reg >> 1) - imhtq_pkg::CNT_W'(1);
    assign pos_m1    = pos_rd_reg - imhtq_pkg::CNT_W'(1);
    assign left_idx  = {idx_reg, 1'b0};
    assign right_idx = {idx_reg, 1'b1};
    assign left_m1   = imhtq_pkg::CNT_W'(left_idx - (imhtq_pkg::CNT_W + 1)'(1));
    assign has_right = right_idx <= {1'b0, count_reg};

    // Pick the smaller child, left on a tie
    assign dn_left  = (rd_a_reg.key < cur_reg.key) &&
                      (!has_right || rd_a_reg.key <= rd_b_reg.key);
    assign dn_right = has_right && (rd_b_reg.key < cur_reg.key) &&
                      (rd_b_reg.key <= rd_a_reg.key);
    assign child    = dn_left ? rd_a_reg : rd_b_reg;

    always_comb
    begin
        flags.in_cmd    = in_cmd;
        flags.present   = valid_reg[in_tid];
        flags.full      = (count_reg == imhtq_pkg::CNT_W'(imhtq_pkg::CAPACITY));
        flags.empty     = (count_reg == '0);
        flags.is_peek   = (cmd_reg == imhtq_pkg::CMD_PEEK);
        flags.hole_last = (idx_reg == count_reg);
        flags.last_less = (rd_b_reg.key < rd_a_reg.key);
        flags.at_root   = (idx_reg == imhtq_pkg::CNT_W'(1));
        flags.up_move   = (rd_a_reg.key > cur_reg.key);
        flags.has_left  = left_idx <= {1'b0, count_reg};
        flags.dn_move   = dn_left || dn_right;
    end

    // Memory addressing and writes for each operation
    always_comb
    begin
        rd_en      = 1'b0;
        addr_a     = idx_m1[imhtq_pkg::SLOT_AW-1:0];
        addr_b     = cnt_m1[imhtq_pkg::SLOT_AW-1:0];
        slot_we    = 1'b0;
        slot_waddr = idx_m1[imhtq_pkg::SLOT_AW-1:0];
        slot_wdata = cur_reg;
        pos_we     = 1'b0;
        pos_waddr  = cur_reg.thr;
        valid_next = valid_reg;
        count_next = count_reg;
        unique case (cmd.op)
            imhtq_pkg::OP_LOAD_INS:
            begin
                count_next = count_reg + imhtq_pkg::CNT_W'(1);
            end
            imhtq_pkg::OP_LOAD_TOP:
            begin
                rd_en  = 1'b1;
                addr_a = '0;
            end
            imhtq_pkg::OP_READ_HOLE:
            begin
                rd_en               = 1'b1;
                addr_a              = pos_m1[imhtq_pkg::SLOT_AW-1:0];
                valid_next[tid_reg] = 1'b0;
            end
            imhtq_pkg::OP_TAKE_HOLE:
            begin
                if (cmd_reg != imhtq_pkg::CMD_PEEK)
                    count_next = cnt_m1;
                if (cmd_reg == imhtq_pkg::CMD_POP)
                    valid_next[rd_a_reg.thr] = 1'b0;
            end
            imhtq_pkg::OP_READ_PARENT:
            begin
                rd_en  = 1'b1;
                addr_a = parent_m1[imhtq_pkg::SLOT_AW-1:0];
            end
            imhtq_pkg::OP_READ_KIDS:
            begin
                rd_en  = 1'b1;
                addr_a = left_m1[imhtq_pkg::SLOT_AW-1:0];
                addr_b = left_idx[imhtq_pkg::SLOT_AW-1:0];
            end
            imhtq_pkg::OP_MOVE_UP:
            begin
                slot_we    = 1'b1;
                slot_wdata = rd_a_reg;
                pos_we     = 1'b1;
                pos_waddr  = rd_a_reg.thr;
            end
            imhtq_pkg::OP_MOVE_DOWN:
            begin
                slot_we    = 1'b1;
                slot_wdata = child;
                pos_we     = 1'b1;
                pos_waddr  = child.thr;
            end
            imhtq_pkg::OP_PLACE:
            begin
                slot_we                  = 1'b1;
                pos_we                   = 1'b1;
                valid_next[cur_reg.thr]  = 1'b1;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        if (rd_en)
        begin
            rd_a_reg <= slot_mem[addr_a];
            rd_b_reg <= slot_mem[addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[pos_waddr] <= idx_reg;
        if (cmd.op == imhtq_pkg::OP_LOAD_REM)
            pos_rd_reg <= pos_mem[in_tid];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    // Working registers and the result
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            imhtq_pkg::OP_LOAD_ERR, imhtq_pkg::OP_LOAD_INS,
            imhtq_pkg::OP_LOAD_TOP, imhtq_pkg::OP_LOAD_REM:
            begin
                cmd_reg        <= in_cmd;
                tid_reg        <= in_tid;
                cur_reg.key    <= in_key;
                cur_reg.thr    <= in_tid;
                res_status_reg <= cmd.err;
                res_thr_reg    <= '0;
                res_key_reg    <= '0;
                if (cmd.op == imhtq_pkg::OP_LOAD_INS)
                    idx_reg <= count_reg + imhtq_pkg::CNT_W'(1);
                else
                    idx_reg <= imhtq_pkg::CNT_W'(1);
            end
            imhtq_pkg::OP_READ_HOLE:
            begin
                idx_reg <= pos_rd_reg;
            end
            imhtq_pkg::OP_TAKE_HOLE:
            begin
                cur_reg <= rd_b_reg;
                if (cmd_reg != imhtq_pkg::CMD_REMOVE)
                begin
                    res_thr_reg <= rd_a_reg.thr;
                    res_key_reg <= rd_a_reg.key;
                end
            end
            imhtq_pkg::OP_MOVE_UP:
            begin
                idx_reg <= idx_reg >> 1;
            end
            imhtq_pkg::OP_MOVE_DOWN:
            begin
                idx_reg <= dn_left ? left_idx[imhtq_pkg::CNT_W-1:0]
                                   : right_idx[imhtq_pkg::CNT_W-1:0];
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
        if (cmd.emit)
            out_data_reg <= {1'b0, count_reg, res_key_reg, res_thr_reg, res_status_reg};
    end

    assign out_data = out_data_reg;

endmodule

// ----- sv/imhtq_checker.sv -----
`timescale 1ns / 1ps

module imhtq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    // A failed command returns no thread and no key
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != imhtq_pkg::ST_OK
        |-> m_axis_tdata[39:3] == '0)
        else $error("error result carries a thread or key");

    // Occupancy never exceeds the capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[46:40] <= 7'd64)
        else $error("occupancy beyond capacity");

    // An empty status means the heap holds nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] == imhtq_pkg::ST_EMPTY
        |-> m_axis_tdata[46:40] == '0)
        else $error("empty status with nonzero occupancy");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind indexed_min_heap_timer_queue imhtq_checker u_imhtq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
